// ===== hw/rtl/rrn_pkg.sv =====
// shared constants, payload structs and reaction tables for the repressilator network block
// no dependencies; used by rrn_prop and repressilator_reaction_network_step
`default_nettype none

package rrn_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int RATE_WIDTH  = 32;
    localparam int NUM_SPECIES = 21;
    localparam int NUM_RXNS    = 48;
    localparam int NUM_SLOTS   = 3;

    localparam int SP_AW    = $clog2(NUM_SPECIES);
    localparam int RX_AW    = $clog2(NUM_RXNS);
    localparam int SLOT_W   = $clog2(NUM_SLOTS);
    localparam int IDX_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int PROP_W   = 64;
    localparam int PROD1_W  = RATE_WIDTH + COUNT_WIDTH;
    localparam int PROD2_W  = PROD1_W + COUNT_WIDTH;

    typedef enum logic [1:0] {
        CMD_LOAD_RATE,
        CMD_SET_COUNT,
        CMD_FIRE,
        CMD_EVAL
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_CLAMP
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [IDX_W-1:0]   index;
        logic [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]  prop_index;
        logic [PROP_W-1:0] propensity;
        logic              last;
        status_t           status;
    } out_t;

    // tag that travels down the propensity pipeline
    typedef struct packed {
        logic             valid;
        logic [RX_AW-1:0] idx;
        logic             last;
    } tag_t;

    typedef struct packed {
        logic             used;
        logic             up;
        logic [SP_AW-1:0] sp;
    } slot_t;

    typedef slot_t [NUM_SLOTS-1:0] stoich_row_t;

    typedef struct packed {
        logic             has_b;
        logic [SP_AW-1:0] a;
        logic [SP_AW-1:0] b;
    } fac_t;

    function automatic slot_t sp_inc(input int unsigned s);
        slot_t r;
        r.used = 1'b1;
        r.up   = 1'b1;
        r.sp   = SP_AW'(s);
        return r;
    endfunction

    function automatic slot_t sp_dec(input int unsigned s);
        slot_t r;
        r.used = 1'b1;
        r.up   = 1'b0;
        r.sp   = SP_AW'(s);
        return r;
    endfunction

    function automatic stoich_row_t row3(input slot_t s0, input slot_t s1, input slot_t s2);
        stoich_row_t r;
        r[0] = s0;
        r[1] = s1;
        r[2] = s2;
        return r;
    endfunction

    function automatic stoich_row_t row1(input slot_t s0);
        stoich_row_t r;
        r    = '0;
        r[0] = s0;
        return r;
    endfunction

    // species changes of each reaction
    function automatic stoich_row_t rxn_stoich(input logic [RX_AW-1:0] rx);
        stoich_row_t r;
        r = '0;
        case (rx) inside
            6'd0:  r = row3(sp_dec(0),  sp_inc(1),  sp_dec(20));
            6'd1:  r = row3(sp_dec(1),  sp_inc(2),  sp_dec(20));
            6'd2:  r = row3(sp_dec(2),  sp_inc(3),  sp_dec(20));
            6'd3:  r = row3(sp_dec(3),  sp_inc(4),  sp_dec(20));
            6'd4:  r = row3(sp_inc(3),  sp_dec(4),  sp_inc(20));
            6'd5:  r = row3(sp_inc(2),  sp_dec(3),  sp_inc(20));
            6'd6:  r = row3(sp_inc(1),  sp_dec(2),  sp_inc(20));
            6'd7:  r = row3(sp_inc(0),  sp_dec(1),  sp_inc(20));
            [6'd8:6'd12]: r = row1(sp_inc(5));
            6'd13: r = row1(sp_dec(5));
            6'd14: r = row1(sp_inc(6));
            6'd15: r = row1(sp_dec(6));
            6'd16: r = row3(sp_dec(6),  sp_dec(7),  sp_inc(8));
            6'd17: r = row3(sp_dec(6),  sp_dec(8),  sp_inc(9));
            6'd18: r = row3(sp_dec(6),  sp_dec(9),  sp_inc(10));
            6'd19: r = row3(sp_dec(6),  sp_dec(10), sp_inc(11));
            6'd20: r = row3(sp_inc(6),  sp_inc(10), sp_dec(11));
            6'd21: r = row3(sp_inc(6),  sp_inc(9),  sp_dec(10));
            6'd22: r = row3(sp_inc(6),  sp_inc(8),  sp_dec(9));
            6'd23: r = row3(sp_inc(6),  sp_inc(7),  sp_dec(8));
            [6'd24:6'd28]: r = row1(sp_inc(12));
            6'd29: r = row1(sp_dec(12));
            6'd30: r = row1(sp_inc(13));
            6'd31: r = row1(sp_dec(13));
            6'd32: r = row3(sp_dec(13), sp_dec(14), sp_inc(15));
            6'd33: r = row3(sp_dec(13), sp_dec(15), sp_inc(16));
            6'd34: r = row3(sp_dec(13), sp_dec(16), sp_inc(17));
            6'd35: r = row3(sp_dec(13), sp_dec(17), sp_inc(18));
            6'd36: r = row3(sp_inc(13), sp_inc(17), sp_dec(18));
            6'd37: r = row3(sp_inc(13), sp_inc(16), sp_dec(17));
            6'd38: r = row3(sp_inc(13), sp_inc(15), sp_dec(16));
            6'd39: r = row3(sp_inc(13), sp_inc(14), sp_dec(15));
            [6'd40:6'd44]: r = row1(sp_inc(19));
            6'd45: r = row1(sp_dec(19));
            6'd46: r = row1(sp_inc(20));
            6'd47: r = row1(sp_dec(20));
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic fac_t fac1(input int unsigned a);
        fac_t f;
        f.has_b = 1'b0;
        f.a     = SP_AW'(a);
        f.b     = '0;
        return f;
    endfunction

    function automatic fac_t fac2(input int unsigned a, input int unsigned b);
        fac_t f;
        f.has_b = 1'b1;
        f.a     = SP_AW'(a);
        f.b     = SP_AW'(b);
        return f;
    endfunction

    // species whose counts multiply each rate
    function automatic fac_t rxn_factors(input logic [RX_AW-1:0] rx);
        fac_t f;
        f = '0;
        case (rx)
            6'd0:  f = fac2(0, 20);
            6'd1:  f = fac2(1, 20);
            6'd2:  f = fac2(2, 20);
            6'd3:  f = fac2(3, 20);
            6'd4:  f = fac1(4);
            6'd5:  f = fac1(3);
            6'd6:  f = fac1(2);
            6'd7:  f = fac1(1);
            6'd8:  f = fac1(0);
            6'd9:  f = fac1(1);
            6'd10: f = fac1(2);
            6'd11: f = fac1(3);
            6'd12: f = fac1(4);
            6'd13: f = fac1(5);
            6'd14: f = fac1(5);
            6'd15: f = fac1(6);
            6'd16: f = fac2(7, 6);
            6'd17: f = fac2(8, 6);
            6'd18: f = fac2(9, 6);
            6'd19: f = fac2(10, 6);
            6'd20: f = fac1(11);
            6'd21: f = fac1(10);
            6'd22: f = fac1(9);
            6'd23: f = fac1(8);
            6'd24: f = fac1(7);
            6'd25: f = fac1(8);
            6'd26: f = fac1(9);
            6'd27: f = fac1(10);
            6'd28: f = fac1(11);
            6'd29: f = fac1(12);
            6'd30: f = fac1(12);
            6'd31: f = fac1(13);
            6'd32: f = fac2(14, 13);
            6'd33: f = fac2(15, 13);
            6'd34: f = fac2(16, 13);
            6'd35: f = fac2(17, 13);
            6'd36: f = fac1(18);
            6'd37: f = fac1(17);
            6'd38: f = fac1(16);
            6'd39: f = fac1(15);
            6'd40: f = fac1(14);
            6'd41: f = fac1(15);
            6'd42: f = fac1(16);
            6'd43: f = fac1(17);
            6'd44: f = fac1(18);
            6'd45: f = fac1(19);
            6'd46: f = fac1(19);
            6'd47: f = fac1(20);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rrn_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// standalone, no package dependency
`default_nettype none

module rrn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rrn_prop.sv =====
// propensity datapath: rate times first count, registered, then times second count
// depends on rrn_pkg
`default_nettype none

module rrn_prop (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire rrn_pkg::tag_t                   tag_in,
    input  wire logic [rrn_pkg::RATE_WIDTH-1:0]  rate,
    input  wire logic [rrn_pkg::COUNT_WIDTH-1:0] count_a,
    input  wire logic [rrn_pkg::COUNT_WIDTH-1:0] count_b,
    output rrn_pkg::tag_t                        tag_out,
    output logic [rrn_pkg::PROP_W-1:0]           prop
);

    rrn_pkg::tag_t                     tag_reg;
    logic [rrn_pkg::PROD1_W-1:0]       m_reg;
    logic [rrn_pkg::COUNT_WIDTH-1:0]   cb_reg;
    logic [rrn_pkg::PROD1_W-1:0]       m_next;
    logic [rrn_pkg::PROD2_W-1:0]       full;

    assign m_next = rrn_pkg::PROD1_W'(rate) * rrn_pkg::PROD1_W'(count_a);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
            m_reg   <= '0;
            cb_reg  <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
            m_reg   <= m_next;
            cb_reg  <= count_b;
        end
    end

    assign full = rrn_pkg::PROD2_W'(m_reg) * rrn_pkg::PROD2_W'(cb_reg);

    // saturate only when the full product can exceed the output field
    if (rrn_pkg::PROD2_W > rrn_pkg::PROP_W)
    begin : g_sat
        assign prop = (|full[rrn_pkg::PROD2_W-1:rrn_pkg::PROP_W]) ? '1
                                                                  : full[rrn_pkg::PROP_W-1:0];
    end
    else
    begin : g_fit
        assign prop = rrn_pkg::PROP_W'(full);
    end

    assign tag_out = tag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/repressilator_reaction_network_step.sv =====
// top level of the repressilator reaction network engine: control, stores and result register
// depends on rrn_pkg, rrn_ram and rrn_prop
`default_nettype none

// Holds 21 species counts and 48 Q16.16 rate constants in small synchronous
// rams, with a valid bit per entry so that everything reads as zero after
// reset without a clearing pass. Load rate and set count are done in the idle
// state, at the transfer. Fire walks the three stoichiometry slots of the
// reaction one at a time, with a read and a write-back state for each species
// touched and a single read state for each unused slot, then registers its
// result. Evaluate streams one propensity per cycle, while the result side
// does not stall, through three registers (ram read, first product, result),
// limited by the single shared multiplier pair and one read per ram port (the
// species store is held twice to give two counts a cycle); the next command
// is taken only once the last propensity has left the pipeline.
// A stall on the result side freezes the evaluate pipeline in place.
module repressilator_reaction_network_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire rrn_pkg::in_t  item,
    output logic               result_valid,
    input  wire logic          result_stall,
    output rrn_pkg::out_t      result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRE_RD,
        S_FIRE_WB,
        S_FIRE_OUT,
        S_EVAL,
        S_DRAIN
    } state_t;

    state_t                              state_reg, state_next;
    logic [rrn_pkg::SLOT_W-1:0]          slot_reg, slot_next;
    logic [rrn_pkg::RX_AW:0]             rxn_reg, rxn_next;
    rrn_pkg::status_t                    fire_status_reg, fire_status_next;
    logic [rrn_pkg::NUM_SPECIES-1:0]     sp_valid_reg, sp_valid_next;
    logic [rrn_pkg::NUM_RXNS-1:0]        rate_valid_reg, rate_valid_next;
    rrn_pkg::tag_t                       tag1_reg, tag1_next;
    logic                                rate_ok_reg, rate_ok_next;
    logic                                a_ok_reg, a_ok_next;
    logic                                b_used_reg, b_used_next;
    logic                                b_ok_reg, b_ok_next;
    rrn_pkg::out_t                       out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    logic                                en;
    logic                                busy;
    logic                                item_xfer;
    logic [rrn_pkg::RX_AW-1:0]           rxn;
    rrn_pkg::stoich_row_t                row;
    rrn_pkg::slot_t                      slot;
    rrn_pkg::fac_t                       fac;
    logic [rrn_pkg::COUNT_WIDTH-1:0]     cur;

    logic                                sp_we;
    logic [rrn_pkg::SP_AW-1:0]           sp_waddr;
    logic [rrn_pkg::COUNT_WIDTH-1:0]     sp_wdata;
    logic                                sp_re_a, sp_re_b;
    logic [rrn_pkg::SP_AW-1:0]           sp_raddr_a, sp_raddr_b;
    logic [rrn_pkg::COUNT_WIDTH-1:0]     sp_rd_a, sp_rd_b;
    logic                                rate_we;
    logic [rrn_pkg::RX_AW-1:0]           rate_waddr;
    logic [rrn_pkg::RATE_WIDTH-1:0]      rate_wdata;
    logic                                rate_re;
    logic [rrn_pkg::RX_AW-1:0]           rate_raddr;
    logic [rrn_pkg::RATE_WIDTH-1:0]      rate_rd;

    logic [rrn_pkg::RATE_WIDTH-1:0]      rate_q;
    logic [rrn_pkg::COUNT_WIDTH-1:0]     ca_q, cb_q;
    rrn_pkg::tag_t                       prop_tag;
    logic [rrn_pkg::PROP_W-1:0]          prop_val;

    // species store, duplicated for two reads a cycle
    rrn_ram #(.WIDTH(rrn_pkg::COUNT_WIDTH), .DEPTH(rrn_pkg::NUM_SPECIES)) u_sp_a (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .re    (sp_re_a),
        .raddr (sp_raddr_a),
        .rdata (sp_rd_a)
    );

    rrn_ram #(.WIDTH(rrn_pkg::COUNT_WIDTH), .DEPTH(rrn_pkg::NUM_SPECIES)) u_sp_b (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (sp_wdata),
        .re    (sp_re_b),
        .raddr (sp_raddr_b),
        .rdata (sp_rd_b)
    );

    rrn_ram #(.WIDTH(rrn_pkg::RATE_WIDTH), .DEPTH(rrn_pkg::NUM_RXNS)) u_rate (
        .clk   (clk),
        .we    (rate_we),
        .waddr (rate_waddr),
        .wdata (rate_wdata),
        .re    (rate_re),
        .raddr (rate_raddr),
        .rdata (rate_rd)
    );

    // entries never written read as zero
    always_comb
    begin
        rate_q = rate_ok_reg ? rate_rd : '0;
        ca_q   = a_ok_reg ? sp_rd_a : '0;
        if (b_used_reg)
        begin
            cb_q = b_ok_reg ? sp_rd_b : '0;
        end
        else
        begin
            cb_q = rrn_pkg::COUNT_WIDTH'(1);
        end
    end

    rrn_prop u_prop (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_in  (tag1_reg),
        .rate    (rate_q),
        .count_a (ca_q),
        .count_b (cb_q),
        .tag_out (prop_tag),
        .prop    (prop_val)
    );

    assign en         = !out_valid_reg || !result_stall;
    assign busy       = tag1_reg.valid || prop_tag.valid;
    assign item_stall = !((state_reg == S_IDLE) && !busy && en);
    assign item_xfer  = item_valid && !item_stall;

    assign rxn  = rxn_reg[rrn_pkg::RX_AW-1:0];
    assign row  = rrn_pkg::rxn_stoich(rxn);
    assign slot = row[slot_reg];
    assign fac  = rrn_pkg::rxn_factors(rxn);
    assign cur  = sp_valid_reg[slot.sp] ? sp_rd_a : '0;

    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        rxn_next         = rxn_reg;
        fire_status_next = fire_status_reg;
        sp_valid_next    = sp_valid_reg;
        rate_valid_next  = rate_valid_reg;
        tag1_next        = tag1_reg;
        rate_ok_next     = rate_ok_reg;
        a_ok_next        = a_ok_reg;
        b_used_next      = b_used_reg;
        b_ok_next        = b_ok_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;

        sp_we      = 1'b0;
        sp_waddr   = slot.sp;
        sp_wdata   = '0;
        sp_re_a    = 1'b0;
        sp_raddr_a = slot.sp;
        sp_re_b    = 1'b0;
        sp_raddr_b = fac.b;
        rate_we    = 1'b0;
        rate_waddr = item.index[rrn_pkg::RX_AW-1:0];
        rate_wdata = item.value[rrn_pkg::RATE_WIDTH-1:0];
        rate_re    = 1'b0;
        rate_raddr = rxn;

        // pipeline output moves into the result register
        if (en)
        begin
            tag1_next                 = '0;
            out_valid_next            = prop_tag.valid;
            out_next.prop_index       = rrn_pkg::IDX_W'(prop_tag.idx);
            out_next.propensity       = prop_val;
            out_next.last             = prop_tag.last;
            out_next.status           = rrn_pkg::ST_OK;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    out_valid_next      = 1'b1;
                    out_next.prop_index = '0;
                    out_next.propensity = '0;
                    out_next.last       = 1'b1;
                    out_next.status     = rrn_pkg::ST_OK;
                    unique case (item.cmd)
                        rrn_pkg::CMD_LOAD_RATE:
                        begin
                            if (item.index < rrn_pkg::IDX_W'(rrn_pkg::NUM_RXNS))
                            begin
                                rate_we = 1'b1;
                                rate_valid_next[item.index[rrn_pkg::RX_AW-1:0]] = 1'b1;
                            end
                            else
                            begin
                                out_next.status = rrn_pkg::ST_RANGE;
                            end
                        end
                        rrn_pkg::CMD_SET_COUNT:
                        begin
                            if (item.index < rrn_pkg::IDX_W'(rrn_pkg::NUM_SPECIES))
                            begin
                                sp_we    = 1'b1;
                                sp_waddr = item.index[rrn_pkg::SP_AW-1:0];
                                sp_wdata = item.value[rrn_pkg::COUNT_WIDTH-1:0];
                                sp_valid_next[item.index[rrn_pkg::SP_AW-1:0]] = 1'b1;
                            end
                            else
                            begin
                                out_next.status = rrn_pkg::ST_RANGE;
                            end
                        end
                        rrn_pkg::CMD_FIRE:
                        begin
                            if (item.index < rrn_pkg::IDX_W'(rrn_pkg::NUM_RXNS))
                            begin
                                out_valid_next   = 1'b0;
                                rxn_next         = (rrn_pkg::RX_AW+1)'(item.index);
                                slot_next        = '0;
                                fire_status_next = rrn_pkg::ST_OK;
                                state_next       = S_FIRE_RD;
                            end
                            else
                            begin
                                out_next.status = rrn_pkg::ST_RANGE;
                            end
                        end
                        rrn_pkg::CMD_EVAL:
                        begin
                            out_valid_next = 1'b0;
                            rxn_next       = '0;
                            state_next     = S_EVAL;
                        end
                    endcase
                end
            end
            S_FIRE_RD:
            begin
                if (slot.used)
                begin
                    sp_re_a    = 1'b1;
                    state_next = S_FIRE_WB;
                end
                else if (slot_reg == rrn_pkg::SLOT_W'(rrn_pkg::NUM_SLOTS - 1))
                begin
                    state_next = S_FIRE_OUT;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            S_FIRE_WB:
            begin
                // species within one reaction are distinct, so no forwarding is needed
                if (slot.up)
                begin
                    if (cur == '1)
                    begin
                        fire_status_next = rrn_pkg::ST_CLAMP;
                    end
                    else
                    begin
                        sp_we    = 1'b1;
                        sp_wdata = cur + 1'b1;
                        sp_valid_next[slot.sp] = 1'b1;
                    end
                end
                else
                begin
                    if (cur == '0)
                    begin
                        fire_status_next = rrn_pkg::ST_CLAMP;
                    end
                    else
                    begin
                        sp_we    = 1'b1;
                        sp_wdata = cur - 1'b1;
                        sp_valid_next[slot.sp] = 1'b1;
                    end
                end
                if (slot_reg == rrn_pkg::SLOT_W'(rrn_pkg::NUM_SLOTS - 1))
                begin
                    state_next = S_FIRE_OUT;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_FIRE_RD;
                end
            end
            S_FIRE_OUT:
            begin
                if (en)
                begin
                    out_valid_next      = 1'b1;
                    out_next.prop_index = '0;
                    out_next.propensity = '0;
                    out_next.last       = 1'b1;
                    out_next.status     = fire_status_reg;
                    state_next          = S_IDLE;
                end
            end
            S_EVAL:
            begin
                if (en)
                begin
                    rate_re         = 1'b1;
                    sp_re_a         = 1'b1;
                    sp_raddr_a      = fac.a;
                    sp_re_b         = 1'b1;
                    tag1_next.valid = 1'b1;
                    tag1_next.idx   = rxn;
                    tag1_next.last  = (rxn_reg == (rrn_pkg::RX_AW+1)'(rrn_pkg::NUM_RXNS - 1));
                    rate_ok_next    = rate_valid_reg[rxn];
                    a_ok_next       = sp_valid_reg[fac.a];
                    b_used_next     = fac.has_b;
                    b_ok_next       = sp_valid_reg[fac.b];
                    rxn_next        = rxn_reg + 1'b1;
                    if (rxn_reg == (rrn_pkg::RX_AW+1)'(rrn_pkg::NUM_RXNS - 1))
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slot_reg        <= '0;
            rxn_reg         <= '0;
            fire_status_reg <= rrn_pkg::ST_OK;
            sp_valid_reg    <= '0;
            rate_valid_reg  <= '0;
            tag1_reg        <= '0;
            rate_ok_reg     <= 1'b0;
            a_ok_reg        <= 1'b0;
            b_used_reg      <= 1'b0;
            b_ok_reg        <= 1'b0;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            rxn_reg         <= rxn_next;
            fire_status_reg <= fire_status_next;
            sp_valid_reg    <= sp_valid_next;
            rate_valid_reg  <= rate_valid_next;
            tag1_reg        <= tag1_next;
            rate_ok_reg     <= rate_ok_next;
            a_ok_reg        <= a_ok_next;
            b_used_reg      <= b_used_next;
            b_ok_reg        <= b_ok_next;
            out_reg         <= out_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_eval_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (rxn_reg < (rrn_pkg::RX_AW+1)'(rrn_pkg::NUM_RXNS)))
        else $error("evaluate counter beyond last reaction");

    a_pipe_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        prop_tag.valid |-> (state_reg == S_EVAL || state_reg == S_DRAIN))
        else $error("propensity in flight outside evaluate");

    a_prop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.propensity != '0) |-> (result.status == rrn_pkg::ST_OK))
        else $error("non-zero propensity with error status");

    a_wb_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIRE_WB) |-> $past(sp_re_a))
        else $error("fire write-back without a preceding read");

endmodule

`default_nettype wire

// ===== test/tb_repressilator_reaction_network_step.sv =====
`timescale 1ns / 1ps
// testbench for repressilator_reaction_network_step: directed and random commands
// against an in-bench predictor of the counts, rates and propensities
// depends on rrn_pkg and the repressilator_reaction_network_step rtl

module tb_repressilator_reaction_network_step;

    import rrn_pkg::*;

    localparam int RANDOM_ITEMS = 98;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 400000;

    logic  clk;
    logic  rst_n;
    logic  item_valid;
    logic  item_stall;
    in_t   item;
    logic  result_valid;
    logic  result_stall;
    out_t  result;

    in_t   queued_commands[$];
    out_t  expected_results[$];

    logic [COUNT_WIDTH-1:0] count_model [NUM_SPECIES];
    logic [RATE_WIDTH-1:0]  rate_model  [NUM_RXNS];

    int    errors;
    int    cycles;
    logic  item_show;
    int    item_hold;
    int    item_run;
    int    result_hold;
    int    result_run;

    repressilator_reaction_network_step DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // the network is three gene modules of 16 reactions each; module g owns
    // promoter states 7g..7g+4, its mrna and its protein, and is repressed
    // by the protein of the module before it
    function automatic void gene_module(input int rx, output int prom, output int mrna,
                                        output int prot, output int rep);
        int g;
        g    = rx / 16;
        prom = 7 * g;
        mrna = 7 * g + 5;
        prot = 7 * g + 6;
        rep  = (g == 0) ? 20 : 7 * g - 1;
    endfunction

    function automatic void step_count(input int sp, input bit up, inout status_t st);
        if (up)
        begin
            if (count_model[sp] == {COUNT_WIDTH{1'b1}})
                st = ST_CLAMP;
            else
                count_model[sp] = count_model[sp] + 1'b1;
        end
        else
        begin
            if (count_model[sp] == '0)
                st = ST_CLAMP;
            else
                count_model[sp] = count_model[sp] - 1'b1;
        end
    endfunction

    function automatic status_t fire_reaction(input int rx);
        int      prom, mrna, prot, rep, k;
        status_t st;
        st = ST_OK;
        gene_module(rx, prom, mrna, prot, rep);
        k = rx % 16;
        if (k < 4)
        begin
            // repressor binds, promoter moves one state up
            step_count(prom + k, 1'b0, st);
            step_count(prom + k + 1, 1'b1, st);
            step_count(rep, 1'b0, st);
        end
        else if (k < 8)
        begin
            // repressor unbinds
            step_count(prom + 7 - k, 1'b1, st);
            step_count(prom + 8 - k, 1'b0, st);
            step_count(rep, 1'b1, st);
        end
        else if (k < 13)
            step_count(mrna, 1'b1, st);
        else if (k == 13)
            step_count(mrna, 1'b0, st);
        else if (k == 14)
            step_count(prot, 1'b1, st);
        else
            step_count(prot, 1'b0, st);
        return st;
    endfunction

    // 32 + 16 + 16 bits fit in 64, so no saturation is possible here
    function automatic logic [PROP_W-1:0] propensity_of(input int rx);
        int                prom, mrna, prot, rep, k;
        logic [PROP_W-1:0] rate;
        rate = PROP_W'(rate_model[rx]);
        gene_module(rx, prom, mrna, prot, rep);
        k = rx % 16;
        if (k < 4)
            return rate * PROP_W'(count_model[prom + k]) * PROP_W'(count_model[rep]);
        else if (k < 8)
            return rate * PROP_W'(count_model[prom + 8 - k]);
        else if (k < 13)
            return rate * PROP_W'(count_model[prom + k - 8]);
        else if (k < 15)
            return rate * PROP_W'(count_model[mrna]);
        else
            return rate * PROP_W'(count_model[prot]);
    endfunction

    function automatic void predict_results(input in_t c);
        out_t r;
        r = '0;
        r.last = 1'b1;
        r.status = ST_OK;
        case (c.cmd)
            CMD_EVAL:
            begin
                for (int rx = 0; rx < NUM_RXNS; rx++)
                begin
                    r.prop_index = IDX_W'(rx);
                    r.propensity = propensity_of(rx);
                    r.last       = (rx == NUM_RXNS - 1);
                    expected_results.push_back(r);
                end
                return;
            end
            CMD_LOAD_RATE:
            begin
                if (c.index < NUM_RXNS)
                    rate_model[c.index] = c.value[RATE_WIDTH-1:0];
                else
                    r.status = ST_RANGE;
            end
            CMD_SET_COUNT:
            begin
                if (c.index < NUM_SPECIES)
                    count_model[c.index] = c.value[COUNT_WIDTH-1:0];
                else
                    r.status = ST_RANGE;
            end
            default:
            begin
                if (c.index < NUM_RXNS)
                    r.status = fire_reaction(c.index);
                else
                    r.status = ST_RANGE;
            end
        endcase
        expected_results.push_back(r);
    endfunction

    // wait before the next transfer, with occasional runs of back-to-back traffic
    function automatic int draw_wait(inout int run);
        if (run > 0)
        begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run = $urandom_range(8, 48);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    function automatic in_t make_cmd(input cmd_t c, input int idx, input logic [31:0] v);
        in_t x;
        x.cmd   = c;
        x.index = IDX_W'(idx);
        x.value = v;
        return x;
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'hFFFF;
            3: return 32'hFFFE;
            4: return $urandom();
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // command driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            item_show = item_valid;
            if (item_valid && !item_stall)
            begin
                predict_results(item);
                item_show = 1'b0;
                item_hold = draw_wait(item_run);
            end
            else if (!item_valid && item_hold > 0)
                item_hold--;
            if (!item_show && item_hold == 0 && queued_commands.size() > 0)
            begin
                item <= queued_commands.pop_front();
                item_show = 1'b1;
            end
            item_valid <= item_show;
        end
    end

    // result monitor and stall generator
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %0h", $time, result);
                    errors++;
                end
                else
                begin
                    out_t want;
                    want = expected_results.pop_front();
                    check_field("prop_index", 64'(want.prop_index), 64'(result.prop_index));
                    check_field("propensity", want.propensity, result.propensity);
                    check_field("last", 64'(want.last), 64'(result.last));
                    check_field("status", 64'(want.status), 64'(result.status));
                end
                result_hold = draw_wait(result_run);
            end
            else if (result_valid && result_hold > 0)
                result_hold--;
            result_stall <= (result_hold > 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int    pick;
        cmd_t  c;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        errors       = 0;
        cycles       = 0;
        item_hold    = 0;
        item_run     = 0;
        result_hold  = 0;
        result_run   = 0;
        foreach (count_model[i])
            count_model[i] = '0;
        foreach (rate_model[i])
            rate_model[i] = '0;

        // directed part
        queued_commands.push_back(make_cmd(CMD_EVAL, 0, 32'h0));
        queued_commands.push_back(make_cmd(CMD_LOAD_RATE, 0, 32'hFFFF_FFFF));
        queued_commands.push_back(make_cmd(CMD_LOAD_RATE, 47, 32'h0001_0000));
        queued_commands.push_back(make_cmd(CMD_LOAD_RATE, 48, 32'h1234_5678));
        queued_commands.push_back(make_cmd(CMD_LOAD_RATE, 63, 32'hFFFF_FFFF));
        queued_commands.push_back(make_cmd(CMD_SET_COUNT, 0, 32'hFFFF_FFFF));
        queued_commands.push_back(make_cmd(CMD_SET_COUNT, 20, 32'hABCD_FFFF));
        queued_commands.push_back(make_cmd(CMD_SET_COUNT, 21, 32'h0000_0005));
        queued_commands.push_back(make_cmd(CMD_SET_COUNT, 63, 32'hFFFF_FFFF));
        queued_commands.push_back(make_cmd(CMD_EVAL, 63, 32'hFFFF_FFFF));
        queued_commands.push_back(make_cmd(CMD_FIRE, 13, 32'h0));
        queued_commands.push_back(make_cmd(CMD_FIRE, 8, 32'h0));
        queued_commands.push_back(make_cmd(CMD_SET_COUNT, 5, 32'h0000_FFFF));
        queued_commands.push_back(make_cmd(CMD_FIRE, 9, 32'h0));
        queued_commands.push_back(make_cmd(CMD_FIRE, 0, 32'h0));
        queued_commands.push_back(make_cmd(CMD_FIRE, 7, 32'h0));
        queued_commands.push_back(make_cmd(CMD_FIRE, 47, 32'h0));
        queued_commands.push_back(make_cmd(CMD_FIRE, 46, 32'h0));
        queued_commands.push_back(make_cmd(CMD_FIRE, 46, 32'h0));
        queued_commands.push_back(make_cmd(CMD_FIRE, 48, 32'h0));
        queued_commands.push_back(make_cmd(CMD_FIRE, 63, 32'hFFFF_FFFF));
        queued_commands.push_back(make_cmd(CMD_EVAL, 42, 32'h0));

        // random part, mostly in-range commands
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                queued_commands.push_back(make_cmd(CMD_LOAD_RATE,
                    $urandom_range(0, NUM_RXNS - 1), pick_rate()));
            else if (pick < 40)
                queued_commands.push_back(make_cmd(CMD_SET_COUNT,
                    $urandom_range(0, NUM_SPECIES - 1), pick_count()));
            else if (pick < 82)
                queued_commands.push_back(make_cmd(CMD_FIRE,
                    $urandom_range(0, NUM_RXNS - 1), $urandom()));
            else if (pick < 90)
                queued_commands.push_back(make_cmd(CMD_EVAL, $urandom_range(0, 63), $urandom()));
            else
            begin
                c = cmd_t'($urandom_range(0, 2));
                queued_commands.push_back(make_cmd(c,
                    (c == CMD_SET_COUNT) ? $urandom_range(NUM_SPECIES, 63)
                                         : $urandom_range(NUM_RXNS, 63),
                    $urandom()));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (queued_commands.size() > 0 || item_valid || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
